FILE: rtl/trsb_pkg.sv
// Shared types and constants for the TCP reset segment builder.
// No dependencies; every other rtl file uses this package by scoped names.
`default_nettype none

package trsb_pkg;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] sequence_number;
		logic [31:0] ack_number;
	} req_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic [3:0]  word_index;
		logic        last_word;
	} word_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		req_t        req;
		logic [15:0] packet_id;
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
	} job_t;

	localparam logic [7:0]  VER_IHL      = 8'h45;
	localparam logic [7:0]  TOS          = 8'h00;
	localparam logic [15:0] TOTAL_LEN    = 16'd40;
	localparam logic [15:0] FRAG_FIELD   = 16'h0000;
	localparam logic [7:0]  TTL          = 8'd64;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [15:0] TCP_LEN      = 16'd20;
	localparam logic [15:0] OFFSET_FLAGS = 16'h5004; // data offset 5, RST only
	localparam logic [15:0] WINDOW       = 16'h0000;
	localparam logic [15:0] URG_PTR      = 16'h0000;

	// Word positions within the 40-byte header
	localparam logic [3:0] WI_VER_LEN   = 4'd0;
	localparam logic [3:0] WI_ID_FRAG   = 4'd1;
	localparam logic [3:0] WI_TTL_CSUM  = 4'd2;
	localparam logic [3:0] WI_SRC_ADDR  = 4'd3;
	localparam logic [3:0] WI_DST_ADDR  = 4'd4;
	localparam logic [3:0] WI_PORTS     = 4'd5;
	localparam logic [3:0] WI_SEQ       = 4'd6;
	localparam logic [3:0] WI_ACK       = 4'd7;
	localparam logic [3:0] WI_OFF_WIN   = 4'd8;
	localparam logic [3:0] WI_CSUM_URG  = 4'd9;

endpackage

`default_nettype wire

FILE: rtl/trsb_front.sv
// Front end: takes requests, stamps the packet id, forms both checksums.
// Uses trsb_pkg. Two register stages, output is a job for the queue.
`default_nettype none

module trsb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire trsb_pkg::req_t req,
	output logic               push_valid,
	input  wire logic          push_ready,
	output trsb_pkg::job_t     push_job
);

	logic                v_s1;
	trsb_pkg::req_t      req_s1;
	logic [15:0]         id_s1;
	logic [15:0]         id_q;

	logic                v_s2;
	trsb_pkg::req_t      req_s2;
	logic [15:0]         id_s2;
	logic [19:0]         ip_sum_s2;
	logic [19:0]         tcp_sum_s2;

	logic                adv2;
	logic                accept;
	logic [19:0]         ip_sum;
	logic [19:0]         tcp_sum;

	// End-around carry fold to 16 bits, then one's complement.
	function automatic logic [15:0] fold_inv(input logic [19:0] s);
		logic [16:0] a;
		logic [15:0] b;
		a = {1'b0, s[15:0]} + {13'd0, s[19:16]};
		b = a[15:0] + {15'd0, a[16]};
		return ~b;
	endfunction

	assign adv2      = !v_s2 || push_ready;
	assign req_stall = v_s1 && !adv2;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		ip_sum = {4'd0, trsb_pkg::VER_IHL, trsb_pkg::TOS}
			+ {4'd0, trsb_pkg::TOTAL_LEN}
			+ {4'd0, id_s1}
			+ {4'd0, trsb_pkg::FRAG_FIELD}
			+ {4'd0, trsb_pkg::TTL, trsb_pkg::PROTO_TCP}
			+ {4'd0, req_s1.source_address[31:16]}
			+ {4'd0, req_s1.source_address[15:0]}
			+ {4'd0, req_s1.dest_address[31:16]}
			+ {4'd0, req_s1.dest_address[15:0]};
		// pseudo-header plus TCP header
		tcp_sum = {4'd0, req_s1.source_address[31:16]}
			+ {4'd0, req_s1.source_address[15:0]}
			+ {4'd0, req_s1.dest_address[31:16]}
			+ {4'd0, req_s1.dest_address[15:0]}
			+ {12'd0, trsb_pkg::PROTO_TCP}
			+ {4'd0, trsb_pkg::TCP_LEN}
			+ {4'd0, req_s1.source_port}
			+ {4'd0, req_s1.dest_port}
			+ {4'd0, req_s1.sequence_number[31:16]}
			+ {4'd0, req_s1.sequence_number[15:0]}
			+ {4'd0, req_s1.ack_number[31:16]}
			+ {4'd0, req_s1.ack_number[15:0]}
			+ {4'd0, trsb_pkg::OFFSET_FLAGS}
			+ {4'd0, trsb_pkg::WINDOW}
			+ {4'd0, trsb_pkg::URG_PTR};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			id_q <= '0;
		end else begin
			if (!req_stall)
				v_s1 <= req_valid;
			if (adv2)
				v_s2 <= v_s1;
			if (accept)
				id_q <= id_q + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			id_s1  <= id_q;
		end
		if (adv2 && v_s1) begin
			req_s2     <= req_s1;
			id_s2      <= id_s1;
			ip_sum_s2  <= ip_sum;
			tcp_sum_s2 <= tcp_sum;
		end
	end

	assign push_valid         = v_s2;
	assign push_job.req       = req_s2;
	assign push_job.packet_id = id_s2;
	assign push_job.ip_csum   = fold_inv(ip_sum_s2);
	assign push_job.tcp_csum  = fold_inv(tcp_sum_s2);

	a_id_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> id_q == $past(id_q) + 16'd1)
		else $error("packet id did not advance on accepted request");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> v_s1)
		else $error("stage 1 lost a stalled request");

endmodule

`default_nettype wire

FILE: rtl/trsb_queue.sv
// Short job queue between front and back ends.
// Uses trsb_pkg for the job type; depth set by DEPTH.
`default_nettype none

module trsb_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire trsb_pkg::job_t push_job,
	output logic               pop_valid,
	input  wire logic          pop,
	output trsb_pkg::job_t     pop_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	trsb_pkg::job_t   mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/trsb_back.sv
// Back end: walks the ten header words of the queue head into an output register.
// Uses trsb_pkg for the job and word types and the field constants.
`default_nettype none

module trsb_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire trsb_pkg::job_t job,
	output logic               pop,
	output logic               word_valid,
	input  wire logic          word_stall,
	output trsb_pkg::word_t    word
);

	logic [3:0]       cnt_q;
	logic             word_valid_q;
	trsb_pkg::word_t  word_q;
	logic             load;
	logic             emit;
	logic             at_last;
	logic [31:0]      hw;

	assign load    = !word_valid_q || !word_stall;
	assign emit    = load && job_valid;
	assign at_last = cnt_q == trsb_pkg::WI_CSUM_URG;
	assign pop     = emit && at_last;

	always_comb begin
		unique case (cnt_q)
			trsb_pkg::WI_VER_LEN:
				hw = {trsb_pkg::VER_IHL, trsb_pkg::TOS, trsb_pkg::TOTAL_LEN};
			trsb_pkg::WI_ID_FRAG:  hw = {job.packet_id, trsb_pkg::FRAG_FIELD};
			trsb_pkg::WI_TTL_CSUM: hw = {trsb_pkg::TTL, trsb_pkg::PROTO_TCP, job.ip_csum};
			trsb_pkg::WI_SRC_ADDR: hw = job.req.source_address;
			trsb_pkg::WI_DST_ADDR: hw = job.req.dest_address;
			trsb_pkg::WI_PORTS:    hw = {job.req.source_port, job.req.dest_port};
			trsb_pkg::WI_SEQ:      hw = job.req.sequence_number;
			trsb_pkg::WI_ACK:      hw = job.req.ack_number;
			trsb_pkg::WI_OFF_WIN:  hw = {trsb_pkg::OFFSET_FLAGS, trsb_pkg::WINDOW};
			trsb_pkg::WI_CSUM_URG: hw = {job.tcp_csum, trsb_pkg::URG_PTR};
			default:               hw = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= trsb_pkg::WI_VER_LEN;
			word_valid_q <= 1'b0;
		end else begin
			if (load)
				word_valid_q <= job_valid;
			if (emit)
				cnt_q <= at_last ? trsb_pkg::WI_VER_LEN : cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q.header_word <= hw;
			word_q.word_index  <= cnt_q;
			word_q.last_word   <= at_last;
		end
	end

	assign word_valid = word_valid_q;
	assign word       = word_q;

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> word.last_word == (word.word_index == trsb_pkg::WI_CSUM_URG))
		else $error("last_word disagrees with word_index");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= trsb_pkg::WI_CSUM_URG)
		else $error("word counter out of range");

endmodule

`default_nettype wire

FILE: rtl/tcp_reset_segment_builder.sv
// TCP reset segment builder, top level.
// Instantiates trsb_front, trsb_queue and trsb_back; types from trsb_pkg.
//
// Request channel (req_valid/req_stall/req): one transfer carries the address
// pair, ports, sequence and acknowledgement numbers of one reset segment.
// Word channel (word_valid/word_stall/word): each request yields ten transfers,
// the 40-byte IPv4 + TCP header in network order, word_index 0..9, last_word
// set on index 9.
// Path: the first word passes the two front-end stages, the queue and the
// output register; the other nine follow one per cycle while word_stall is
// low. Throughput: one word per cycle while word_stall is low, each request
// yielding ten words. The front end takes requests back to back until the
// job queue (QUEUE_DEPTH entries) and its two stages are full, then raises
// req_stall.
// Reset clears the packet id counter to 0, empties the queue and drops any
// word in flight. While word_stall is high the current word holds; the queue
// keeps absorbing requests until full.
`default_nettype none

module tcp_reset_segment_builder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire trsb_pkg::req_t req,
	output logic                word_valid,
	input  wire logic           word_stall,
	output trsb_pkg::word_t     word
);

	logic            push_valid;
	logic            push_ready;
	trsb_pkg::job_t  push_job;
	logic            job_valid;
	logic            pop;
	trsb_pkg::job_t  job;

	trsb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	trsb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (job_valid),
		.pop        (pop),
		.pop_job    (job)
	);

	trsb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.pop        (pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

endmodule

`default_nettype wire

FILE: tb/trsb_header_checker.sv
// Scoreboard for the TCP reset segment builder: predicts the ten header words of
// every request transfer and checks them against the word channel.
// Depends on trsb_pkg for the request/word types and the header constants.

module trsb_header_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  trsb_pkg::req_t  req,
	input  logic            word_valid,
	input  logic            word_stall,
	input  trsb_pkg::word_t word,
	output int              fail_count,
	output int              words_outstanding
);

	trsb_pkg::word_t expected_words[$];
	trsb_pkg::word_t oldest_word;
	logic [15:0]     next_packet_id = '0;
	int              mismatches = 0;
	int              words_checked = 0;

	function automatic logic [31:0] half_sum(logic [31:0] w);
		return {16'h0000, w[31:16]} + {16'h0000, w[15:0]};
	endfunction

	// end-around carry fold, then one's complement
	function automatic logic [15:0] fold_and_invert(logic [31:0] total);
		while (total[31:16] != 16'h0000)
			total = half_sum(total);
		return ~total[15:0];
	endfunction

	task automatic queue_header(trsb_pkg::req_t r);
		logic [31:0]     hdr[10];
		logic [31:0]     total;
		trsb_pkg::word_t w;
		int              k;
		hdr[trsb_pkg::WI_VER_LEN]  = {trsb_pkg::VER_IHL, trsb_pkg::TOS, trsb_pkg::TOTAL_LEN};
		hdr[trsb_pkg::WI_ID_FRAG]  = {next_packet_id, trsb_pkg::FRAG_FIELD};
		hdr[trsb_pkg::WI_TTL_CSUM] = {trsb_pkg::TTL, trsb_pkg::PROTO_TCP, 16'h0000};
		hdr[trsb_pkg::WI_SRC_ADDR] = r.source_address;
		hdr[trsb_pkg::WI_DST_ADDR] = r.dest_address;
		total = '0;
		for (k = trsb_pkg::WI_VER_LEN; k <= trsb_pkg::WI_DST_ADDR; k++)
			total += half_sum(hdr[k]);
		hdr[trsb_pkg::WI_TTL_CSUM][15:0] = fold_and_invert(total);

		hdr[trsb_pkg::WI_PORTS]    = {r.source_port, r.dest_port};
		hdr[trsb_pkg::WI_SEQ]      = r.sequence_number;
		hdr[trsb_pkg::WI_ACK]      = r.ack_number;
		hdr[trsb_pkg::WI_OFF_WIN]  = {trsb_pkg::OFFSET_FLAGS, trsb_pkg::WINDOW};
		hdr[trsb_pkg::WI_CSUM_URG] = {16'h0000, trsb_pkg::URG_PTR};
		// pseudo-header: both addresses, protocol, TCP length
		total = half_sum(r.source_address) + half_sum(r.dest_address)
			+ {24'h000000, trsb_pkg::PROTO_TCP} + {16'h0000, trsb_pkg::TCP_LEN};
		for (k = trsb_pkg::WI_PORTS; k <= trsb_pkg::WI_CSUM_URG; k++)
			total += half_sum(hdr[k]);
		hdr[trsb_pkg::WI_CSUM_URG][31:16] = fold_and_invert(total);

		for (k = trsb_pkg::WI_VER_LEN; k <= trsb_pkg::WI_CSUM_URG; k++) begin
			w.header_word = hdr[k];
			w.word_index  = 4'(k);
			w.last_word   = (k == trsb_pkg::WI_CSUM_URG);
			expected_words.push_back(w);
		end
		next_packet_id = next_packet_id + 16'd1;
	endtask

	task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
		if (mismatches < 10)
			$display("mismatch at word %0d: %s expected 0x%h got 0x%h",
				words_checked, what, exp_v, got_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			next_packet_id = '0;
			fail_count <= 0;
			words_outstanding <= 0;
		end else begin
			if (word_valid && !word_stall) begin
				if (expected_words.size() == 0) begin
					report("word with nothing pending, header_word", '0, word.header_word);
				end else begin
					oldest_word = expected_words.pop_front();
					if (word.header_word !== oldest_word.header_word)
						report("header_word", oldest_word.header_word, word.header_word);
					if (word.word_index !== oldest_word.word_index)
						report("word_index", 32'(oldest_word.word_index), 32'(word.word_index));
					if (word.last_word !== oldest_word.last_word)
						report("last_word", 32'(oldest_word.last_word), 32'(word.last_word));
				end
				words_checked++;
			end
			if (req_valid && !req_stall)
				queue_header(req);
			fail_count <= mismatches;
			words_outstanding <= expected_words.size();
		end
	end

endmodule

FILE: tb/tb_tcp_reset_segment_builder.sv
// Testbench top for tcp_reset_segment_builder: drives requests and word-channel
// stalls, including checksum corner cases, and reports the verdict.
// Depends on trsb_pkg, the block under test and trsb_header_checker.

module tb_tcp_reset_segment_builder;

	localparam int CYCLE_LIMIT  = 2_500_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 380;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	trsb_pkg::req_t  req = '0;
	logic            word_valid;
	logic            word_stall = 1'b0;
	trsb_pkg::word_t word;

	int fail_count;
	int words_outstanding;
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	bit long_hold = 1'b0;
	int hold_count = 0;
	int cycle_count = 0;
	int sent_count = 0;

	tcp_reset_segment_builder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

	trsb_header_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.req               (req),
		.word_valid        (word_valid),
		.word_stall        (word_stall),
		.word              (word),
		.fail_count        (fail_count),
		.words_outstanding (words_outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tcp_reset_segment_builder verification failed");
			$finish;
		end
	end

	// word channel back-pressure; a long hold lets the request queue fill up
	always @(posedge clk) begin
		if (long_hold) begin
			word_stall <= 1'b1;
			hold_count++;
			if (hold_count >= HOLD_CYCLES) begin
				long_hold = 1'b0;
				hold_count = 0;
			end
		end else if (rx_idle_on) begin
			word_stall <= ($urandom_range(99) < 37);
		end else begin
			word_stall <= 1'b0;
		end
	end

	function automatic trsb_pkg::req_t make_req(logic [31:0] src, logic [31:0] dst,
			logic [15:0] sport, logic [15:0] dport, logic [31:0] seq, logic [31:0] ack);
		trsb_pkg::req_t r;
		r.source_address  = src;
		r.dest_address    = dst;
		r.source_port     = sport;
		r.dest_port       = dport;
		r.sequence_number = seq;
		r.ack_number      = ack;
		return r;
	endfunction

	function automatic trsb_pkg::req_t random_request();
		return make_req($urandom, $urandom, 16'($urandom), 16'($urandom), $urandom, $urandom);
	endfunction

	task automatic send(trsb_pkg::req_t r);
		while (tx_idle_on && $urandom_range(99) < 37) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
	endtask

	// stop offering until every predicted word has been seen
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [16:0] ip_base;
		logic [15:0] tcp_base;
		int          i;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send(make_req('0, '0, '0, '0, '0, '0));
		send(make_req('1, '1, '1, '1, '1, '1));
		send(make_req('1, '0, '0, '0, '0, '0));
		send(make_req('0, '1, '0, '0, '0, '0));
		send(make_req('0, '0, 16'hffff, '0, '0, '0));
		send(make_req('0, '0, '0, 16'hffff, '0, '0));
		send(make_req('0, '0, '0, '0, '1, '0));
		send(make_req('0, '0, '0, '0, '0, '1));
		send(make_req(32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 16'h5555,
			32'haaaa_aaaa, 32'h5555_5555));
		send(make_req(32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 16'haaaa,
			32'h5555_5555, 32'haaaa_aaaa));
		send(make_req(32'hc0a8_0001, 32'h0a00_0002, 16'd80, 16'd49152,
			32'h1234_5678, 32'h9abc_def0));

		// IP header sum lands on 0xffff, so its checksum is zero
		ip_base = {1'b0, trsb_pkg::VER_IHL, trsb_pkg::TOS} + {1'b0, trsb_pkg::TOTAL_LEN}
			+ {1'b0, trsb_pkg::TTL, trsb_pkg::PROTO_TCP} + {1'b0, sent_count[15:0]};
		ip_base = {1'b0, ip_base[15:0]} + {16'h0000, ip_base[16]};
		send(make_req({~ip_base[15:0], 16'h0000}, '0, '0, '0, '0, '0));

		// TCP sum lands on 0xffff with zero addresses, ports and ack
		tcp_base = {8'h00, trsb_pkg::PROTO_TCP} + trsb_pkg::TCP_LEN + trsb_pkg::OFFSET_FLAGS;
		send(make_req('0, '0, '0, '0, {~tcp_base, 16'h0000}, '0));
		for (i = 0; i < 6; i++)
			send(random_request());

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			tx_idle_on = !(i >= 120 && i < 200);
			rx_idle_on = tx_idle_on;
			if (i == 250)
				long_hold = 1'b1;
			if (i == 320)
				drain();
			send(random_request());
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_outstanding == 0)
			$display("tcp_reset_segment_builder verification clean");
		else
			$display("tcp_reset_segment_builder verification failed");
		$finish;
	end

endmodule
